[hdl/rfr_pkg.sv]
`timescale 1ns / 1ps

package rfr_pkg;

    localparam int RELAY_COUNT = 8;
    localparam int RELAY_IDX_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
    localparam logic [7:0] RELAY_LIMIT = 8'(RELAY_COUNT);

    localparam logic [7:0]  SOF_BYTE      = 8'hA5;
    localparam logic [7:0]  REPORT_STATE  = 8'h20;
    localparam logic [7:0]  REPORT_SWITCH = 8'h21;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] SILENCE_RESET = 16'd10000;
    localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

    // byte positions within a frame, SOF is position 0
    localparam logic [2:0] POS_HUNT   = 3'd0;
    localparam logic [2:0] POS_CMD    = 3'd1;
    localparam logic [2:0] POS_INDEX  = 3'd2;
    localparam logic [2:0] POS_VALUE  = 3'd3;
    localparam logic [2:0] POS_SEQ    = 3'd4;
    localparam logic [2:0] POS_CRC_LO = 3'd5;
    localparam logic [2:0] POS_CRC_HI = 3'd6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic       is_tick;
        logic       is_sof;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       change_valid;
        logic [2:0] relay_index;
        logic       new_state;
        logic       from_switch;
        logic       healthy;
        logic       crc_error;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/rfr_in_if.sv]
`timescale 1ns / 1ps

interface rfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

[hdl/rfr_out_if.sv]
`timescale 1ns / 1ps

interface rfr_out_if;
    logic       valid;
    logic       ready;
    logic       change_valid;
    logic [2:0] relay_index;
    logic       new_state;
    logic       from_switch;
    logic       healthy;
    logic       crc_error;

    modport source (output valid, output change_valid, output relay_index, output new_state,
                    output from_switch, output healthy, output crc_error, input ready);
    modport sink   (input valid, input change_valid, input relay_index, input new_state,
                    input from_switch, input healthy, input crc_error, output ready);
endinterface

[hdl/rfr_front.sv]
`timescale 1ns / 1ps

module rfr_front
    import rfr_pkg::*;
(
    rfr_in_if.sink item,
    input  logic   q_full,
    output logic   push,
    output item_t  push_item
);

    assign item.ready = !q_full;
    assign push       = item.valid && !q_full;

    always_comb
    begin
        push_item.is_tick = item.op;
        push_item.is_sof  = (item.rx_byte == SOF_BYTE);
        push_item.data    = item.rx_byte;
    end

endmodule

[hdl/rfr_queue.sv]
`timescale 1ns / 1ps

module rfr_queue
    import rfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/rfr_back.sv]
`timescale 1ns / 1ps

module rfr_back
    import rfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       head,
    input  logic        empty,
    output logic        pop,
    input  logic [15:0] silence_limit,
    rfr_out_if.source   result
);

    logic [2:0]             pos_reg, pos_next;
    logic [15:0]            crc_reg, crc_next;
    logic [7:0]             cmd_reg, cmd_next;
    logic [7:0]             idx_reg, idx_next;
    logic                   val_reg, val_next;
    logic [7:0]             crc_lo_reg, crc_lo_next;
    logic [RELAY_COUNT-1:0] relays_reg, relays_next;
    logic [15:0]            silence_reg, silence_next;
    logic                   healthy_reg, healthy_next;
    logic                   out_valid_reg;
    result_t                res_reg, res_next;

    logic [15:0]            silence_inc;
    logic [RELAY_IDX_W-1:0] rel_sel;
    logic                   idx_ok;
    logic                   is_relay_cmd;

    assign pop = !empty && (!out_valid_reg || result.ready);

    assign silence_inc  = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 16'd1;
    assign rel_sel      = idx_reg[RELAY_IDX_W-1:0];
    assign idx_ok       = (idx_reg < RELAY_LIMIT);
    assign is_relay_cmd = (cmd_reg == REPORT_STATE) || (cmd_reg == REPORT_SWITCH);

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        crc_lo_next  = crc_lo_reg;
        relays_next  = relays_reg;
        silence_next = silence_reg;
        healthy_next = healthy_reg;
        res_next     = '0;

        if (head.is_tick)
        begin
            silence_next = silence_inc;
            if (silence_inc > silence_limit)
            begin
                healthy_next = 1'b0;
            end
        end
        else
        begin
            silence_next = '0;
            healthy_next = 1'b1;
            case (pos_reg)
                POS_HUNT:
                begin
                    if (head.is_sof)
                    begin
                        pos_next = POS_CMD;
                        crc_next = CRC_INIT;
                    end
                end
                POS_CMD:
                begin
                    cmd_next = head.data;
                    crc_next = crc16_byte(crc_reg, head.data);
                    pos_next = POS_INDEX;
                end
                POS_INDEX:
                begin
                    idx_next = head.data;
                    crc_next = crc16_byte(crc_reg, head.data);
                    pos_next = POS_VALUE;
                end
                POS_VALUE:
                begin
                    val_next = (head.data != 8'h00);
                    crc_next = crc16_byte(crc_reg, head.data);
                    pos_next = POS_SEQ;
                end
                POS_SEQ:
                begin
                    crc_next = crc16_byte(crc_reg, head.data);
                    pos_next = POS_CRC_LO;
                end
                POS_CRC_LO:
                begin
                    crc_lo_next = head.data;
                    pos_next    = POS_CRC_HI;
                end
                POS_CRC_HI:
                begin
                    pos_next = POS_HUNT;
                    crc_next = CRC_INIT;
                    if ({head.data, crc_lo_reg} != crc_reg)
                    begin
                        res_next.crc_error = 1'b1;
                    end
                    else if (is_relay_cmd && idx_ok && (relays_reg[rel_sel] != val_reg))
                    begin
                        relays_next[rel_sel] = val_reg;
                        res_next.change_valid = 1'b1;
                        res_next.relay_index  = idx_reg[2:0];
                        res_next.new_state    = val_reg;
                        res_next.from_switch  = (cmd_reg == REPORT_SWITCH);
                    end
                end
                default:
                begin
                    pos_next = POS_HUNT;
                end
            endcase
        end
        res_next.healthy = healthy_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg    <= cmd_next;
            idx_reg    <= idx_next;
            val_reg    <= val_next;
            crc_lo_reg <= crc_lo_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HUNT;
            crc_reg       <= CRC_INIT;
            relays_reg    <= '0;
            silence_reg   <= '0;
            healthy_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pos_reg     <= pos_next;
                crc_reg     <= crc_next;
                relays_reg  <= relays_next;
                silence_reg <= silence_next;
                healthy_reg <= healthy_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.change_valid = res_reg.change_valid;
    assign result.relay_index  = res_reg.relay_index;
    assign result.new_state    = res_reg.new_state;
    assign result.from_switch  = res_reg.from_switch;
    assign result.healthy      = res_reg.healthy;
    assign result.crc_error    = res_reg.crc_error;

endmodule

[hdl/relay_frame_receiver.sv]
// Result path: an accepted item is first written into the queue, then the back end pops it and
// registers its result word in the output register.
// Throughput: one word per cycle while results are taken; CRC byte update and relay write as a word pops.
// A stalled result holds in the output register while the two-entry queue takes words until it is full.
// Reset (rst_n, async, active low): queue and result empty, frame hunt for SOF, relays off,
// link healthy, silence count zero, silence limit 10000.
`timescale 1ns / 1ps

module relay_frame_receiver
    import rfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rfr_in_if.sink      item,
    rfr_out_if.source   result,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    item_t       push_item;
    item_t       head;
    logic [15:0] silence_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_limit_reg <= SILENCE_RESET;
        end
        else if (cfg_we)
        begin
            silence_limit_reg <= cfg_data;
        end
    end

    rfr_front u_front (
        .item      (item),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    rfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .silence_limit (silence_limit_reg),
        .result        (result)
    );

endmodule

[hdl/rfr_checker.sv]
`timescale 1ns / 1ps

module rfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       change_valid,
    input logic [2:0] relay_index,
    input logic       new_state,
    input logic       from_switch,
    input logic       healthy,
    input logic       crc_error
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(change_valid) &&
        $stable(relay_index) && $stable(new_state) && $stable(from_switch) &&
        $stable(healthy) && $stable(crc_error))
        else $error("result word changed while stalled");

    // event fields are zero when no change is reported
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !change_valid |-> relay_index == 3'd0 && !new_state && !from_switch)
        else $error("event fields set without a change");

    // a change needs a good frame, whose last byte just marked the link healthy
    a_change: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && change_valid |-> !crc_error && healthy)
        else $error("change reported with crc error or unhealthy link");

    // a CRC error ends a frame, which is a byte, so the link is healthy
    a_crc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && crc_error |-> healthy)
        else $error("crc error on unhealthy link");

    a_reset: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind relay_frame_receiver rfr_checker u_rfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .change_valid (result.change_valid),
    .relay_index  (result.relay_index),
    .new_state    (result.new_state),
    .from_switch  (result.from_switch),
    .healthy      (result.healthy),
    .crc_error    (result.crc_error)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rfr_pkg::*;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   SETTLE_CYCLES  = 4;
    localparam int   RANDOM_WORDS   = 1840;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    rfr_in_if  item_bus ();
    rfr_out_if result_bus ();

    relay_frame_receiver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_bus),
        .result   (result_bus),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver model state
    logic [2:0]             frame_pos;
    logic [7:0]             frame_buf [6];
    logic [15:0]            frame_crc;
    logic [RELAY_COUNT-1:0] relay_bits;
    logic [15:0]            quiet_ticks;
    logic                   link_ok;
    logic [15:0]            quiet_limit;

    result_t pending_reports [$];
    int      mismatches = 0;
    int      words_sent = 0;
    int      burst_left = 0;
    int      hold_cycles = 0;
    int      quiet_cycles = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       rx_phase = 0;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        int          i;
        acc = crc;
        for (i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    task automatic reset_model();
        frame_pos   = POS_HUNT;
        frame_crc   = CRC_INIT;
        relay_bits  = '0;
        quiet_ticks = '0;
        link_ok     = 1'b1;
        quiet_limit = SILENCE_RESET;
        foreach (frame_buf[i])
            frame_buf[i] = 8'h00;
    endtask

    // advances the model by one word and returns the report it must produce
    function automatic result_t receive_word(input logic is_tick, input logic [7:0] b);
        result_t    r;
        logic [7:0] cmd;
        logic [7:0] idx;
        logic       lvl;
        r = '0;
        if (is_tick == OP_TICK)
        begin
            if (quiet_ticks != SILENCE_MAX)
                quiet_ticks++;
            if (quiet_ticks > quiet_limit)
                link_ok = 1'b0;
        end
        else
        begin
            quiet_ticks = '0;
            link_ok     = 1'b1;
            if (frame_pos == POS_HUNT)
            begin
                if (b == SOF_BYTE)
                begin
                    frame_pos = POS_CMD;
                    frame_crc = CRC_INIT;
                end
            end
            else
            begin
                frame_buf[frame_pos - 3'd1] = b;
                if (frame_pos <= POS_SEQ)
                    frame_crc = crc_add(frame_crc, b);
                if (frame_pos == POS_CRC_HI)
                begin
                    frame_pos = POS_HUNT;
                    cmd = frame_buf[0];
                    idx = frame_buf[1];
                    if ({frame_buf[5], frame_buf[4]} != frame_crc)
                        r.crc_error = 1'b1;
                    else if ((cmd == REPORT_STATE || cmd == REPORT_SWITCH) && idx < RELAY_LIMIT)
                    begin
                        lvl = (frame_buf[2] != 8'h00);
                        if (relay_bits[idx[RELAY_IDX_W-1:0]] != lvl)
                        begin
                            relay_bits[idx[RELAY_IDX_W-1:0]] = lvl;
                            r.change_valid  = 1'b1;
                            r.relay_index   = 3'(idx);
                            r.new_state     = lvl;
                            r.from_switch   = (cmd == REPORT_SWITCH);
                        end
                    end
                    frame_crc = CRC_INIT;
                end
                else
                    frame_pos++;
            end
        end
        r.healthy = link_ok;
        return r;
    endfunction

    // scoreboard: predict on input handshake, compare on output handshake
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
                pending_reports.push_back(receive_word(item_bus.op, item_bus.rx_byte));
            if (result_bus.valid && result_bus.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result word with no report expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (result_bus.change_valid !== want.change_valid)
                    begin
                        $error("change_valid: expected %0d, got %0d",
                               want.change_valid, result_bus.change_valid);
                        mismatches++;
                    end
                    if (result_bus.relay_index !== want.relay_index)
                    begin
                        $error("relay_index: expected %0d, got %0d",
                               want.relay_index, result_bus.relay_index);
                        mismatches++;
                    end
                    if (result_bus.new_state !== want.new_state)
                    begin
                        $error("new_state: expected %0d, got %0d",
                               want.new_state, result_bus.new_state);
                        mismatches++;
                    end
                    if (result_bus.from_switch !== want.from_switch)
                    begin
                        $error("from_switch: expected %0d, got %0d",
                               want.from_switch, result_bus.from_switch);
                        mismatches++;
                    end
                    if (result_bus.healthy !== want.healthy)
                    begin
                        $error("healthy: expected %0d, got %0d",
                               want.healthy, result_bus.healthy);
                        mismatches++;
                    end
                    if (result_bus.crc_error !== want.crc_error)
                    begin
                        $error("crc_error: expected %0d, got %0d",
                               want.crc_error, result_bus.crc_error);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: forced hold-off first, otherwise a randomly chosen stall pattern
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:     result_bus.ready <= 1'b1;
                RX_RANDOM:   result_bus.ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: result_bus.ready <= ((rx_phase % 7) >= 3);
                default:     result_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic is_tick, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_bus.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_bus.valid   <= 1'b1;
        item_bus.op      <= is_tick;
        item_bus.rx_byte <= b;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] idx,
                              input logic [7:0] val, input logic [7:0] seq,
                              input bit bad_crc, input bit with_ticks);
        logic [7:0]  body [4];
        logic [15:0] crc;
        body = '{cmd, idx, val, seq};
        crc  = CRC_INIT;
        foreach (body[i])
            crc = crc_add(crc, body[i]);
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_word(OP_BYTE, SOF_BYTE);
        foreach (body[i])
        begin
            // ticks inside a frame must not disturb the byte position
            if (with_ticks && $urandom_range(0, 9) == 0)
                send_ticks($urandom_range(1, 3));
            send_word(OP_BYTE, body[i]);
        end
        send_word(OP_BYTE, crc[7:0]);
        send_word(OP_BYTE, crc[15:8]);
    endtask

    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_silence_limit(input logic [15:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        quiet_limit  = value;
    endtask

    task automatic test_directed();
        send_word(OP_BYTE, 8'h00);                                // discarded while hunting
        send_word(OP_TICK, 8'hFF);
        send_frame(REPORT_SWITCH, 8'h07, 8'hFF, 8'h00, 0, 0);     // relay 7 on
        send_frame(REPORT_STATE, 8'h07, 8'h01, SOF_BYTE, 0, 0);   // same level, SOF as data
        send_frame(REPORT_STATE, RELAY_LIMIT, 8'h01, 8'hFF, 0, 0);
        send_frame(8'hFF, 8'h00, 8'h00, 8'h00, 0, 0);
        wait_idle();
    endtask

    task automatic test_silence_limits();
        // short silence under the reset limit, then small limits including zero
        send_ticks(20);
        send_word(OP_BYTE, 8'h00);
        write_silence_limit(16'd0);
        send_ticks(2);
        send_word(OP_BYTE, 8'h3C);
        write_silence_limit(16'd1);
        send_ticks(3);
        send_word(OP_BYTE, 8'hC3);
        write_silence_limit(16'd5);
        send_ticks(7);
        send_word(OP_BYTE, 8'h00);
        wait_idle();
    endtask

    task automatic random_traffic(input int count);
        int         stop_at;
        int         pick;
        logic [7:0] cmd;
        logic [7:0] idx;
        logic [7:0] val;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                pick = $urandom_range(0, 9);
                cmd = (pick < 4) ? REPORT_STATE : (pick < 8) ? REPORT_SWITCH
                                                              : 8'($urandom_range(0, 255));
                idx = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, RELAY_COUNT - 1))
                                                 : 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 2);
                val = (pick == 0) ? 8'h00 : (pick == 1) ? 8'h01 : 8'($urandom_range(0, 255));
                send_frame(cmd, idx, val, 8'($urandom_range(0, 255)),
                           $urandom_range(0, 9) == 0, 1);
            end
            else if (pick < 80)
                send_word(OP_BYTE, 8'($urandom_range(0, 255)));
            else if (pick < 90)
                send_ticks($urandom_range(1, 8));
            else
            begin
                // cut-off frame: the next frame's bytes get absorbed into it
                send_word(OP_BYTE, SOF_BYTE);
                repeat ($urandom_range(0, 5)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end
        wait_idle();
    endtask

    task automatic test_random_frames();
        write_silence_limit(16'd0);
        random_traffic(RANDOM_WORDS / 4);
        write_silence_limit(16'($urandom_range(1, 8)));
        random_traffic(RANDOM_WORDS / 4);
        write_silence_limit(16'($urandom_range(9, 300)));
        random_traffic(RANDOM_WORDS / 4);
        write_silence_limit(16'hFFFF);
        random_traffic(RANDOM_WORDS / 4);
    endtask

    task automatic test_backpressure();
        int n;
        hold_cycles = 200;
        for (n = 0; n < 5; n++)
            send_frame(($urandom_range(0, 1) == 0) ? REPORT_STATE : REPORT_SWITCH,
                       8'($urandom_range(0, RELAY_COUNT - 1)), 8'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 0, 0);
        wait_idle();
    endtask

    task automatic test_limit_change();
        // limit at max holds; a lower limit then trips on the count already reached
        write_silence_limit(16'hFFFF);
        send_ticks(12);
        write_silence_limit(16'd3);
        send_ticks(2);
        send_word(OP_BYTE, 8'h5A);
        wait_idle();
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_data              = '0;
        item_bus.valid        = 1'b0;
        item_bus.op           = OP_BYTE;
        item_bus.rx_byte      = 8'h00;
        result_bus.ready      = 1'b0;
        reset_model();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_silence_limits();
        test_random_frames();
        test_backpressure();
        test_limit_change();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
